// File: hdl/keyword_cipher_decoder_unit_macros.svh
// Assertion macros shared by the keyword cipher decoder modules.
// Each macro expects a clock named aclk and an active-low reset named aresetn.
`ifndef KEYWORD_CIPHER_DECODER_UNIT_MACROS_SVH
`define KEYWORD_CIPHER_DECODER_UNIT_MACROS_SVH

// Property checked on every clock edge outside of reset.
`define KCD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on the clock edge that follows a reset cycle.
`define KCD_ASSERT_AFTER_RESET(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> prop) else $error(msg);

`endif

// File: hdl/kcd_pkg.sv
// Shared types, constants and helper functions for the keyword cipher decoder.
// No dependencies; imported by every module of the block.
package kcd_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int IDX_W       = 5;
    localparam int CNT_W       = 5;
    localparam int CHAR_W      = 8;
    localparam int OP_W        = 2;

    // Operation codes carried in the low bits of s_tdata.
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_BACKTICK = 8'h60;
    localparam logic [CHAR_W-1:0] CHAR_SPACE    = 8'h20;

    typedef logic [NUM_LETTERS-1:0] letter_mask_t;

    // Result of classifying one byte as a letter of either case.
    typedef struct packed {
        logic             is_letter;
        logic [IDX_W-1:0] idx;
    } letter_info_t;

    // Update command from the datapath to the key store.
    typedef struct packed {
        logic             clear;
        logic             add;
        logic [IDX_W-1:0] idx;
    } key_cmd_t;

    // Map A-Z and a-z onto 0..25; other bytes are flagged as non-letters.
    function automatic letter_info_t letter_info(input logic [CHAR_W-1:0] c);
        letter_info_t info;
        info.is_letter = 1'b0;
        info.idx       = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
            info.is_letter = 1'b1;
            info.idx       = IDX_W'(c - CHAR_UPPER_A);
        end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
            info.is_letter = 1'b1;
            info.idx       = IDX_W'(c - CHAR_LOWER_A);
        end
        return info;
    endfunction

    // Number of set bits in a letter mask; at most 26, so five bits suffice.
    function automatic logic [CNT_W-1:0] count_letters(input letter_mask_t m);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < NUM_LETTERS; i++) begin
            n = n + CNT_W'(m[i]);
        end
        return n;
    endfunction

endpackage

// File: hdl/kcd_key_store.sv
// Key state of the keyword cipher decoder: used-letter mask, per-letter
// cipher positions and the count of distinct key letters. Depends on kcd_pkg.
`include "keyword_cipher_decoder_unit_macros.svh"

module kcd_key_store
    import kcd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  key_cmd_t         cmd,
    input  logic [IDX_W-1:0] rd_idx,
    output letter_mask_t     used,
    output logic [CNT_W-1:0] key_count,
    output logic [CNT_W-1:0] rd_pos
);

    letter_mask_t     used_reg, used_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_mem [NUM_LETTERS];
    logic             add_new;

    // A key letter only counts the first time it is seen since the last clear.
    assign add_new = cmd.add && !used_reg[cmd.idx];

    always_comb begin
        used_next  = used_reg;
        count_next = count_reg;
        if (cmd.clear) begin
            used_next  = '0;
            count_next = '0;
        end else if (add_new) begin
            used_next[cmd.idx] = 1'b1;
            count_next         = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= '0;
            count_reg <= '0;
        end else begin
            used_reg  <= used_next;
            count_reg <= count_next;
        end
    end

    // Positions need no reset: an entry is read only while its used bit is set.
    always_ff @(posedge aclk) begin
        if (!cmd.clear && add_new) begin
            pos_mem[cmd.idx] <= count_reg;
        end
    end

    assign used      = used_reg;
    assign key_count = count_reg;
    assign rd_pos    = pos_mem[rd_idx];

    `KCD_ASSERT(a_count_matches_mask, $countones(used_reg) == 32'(count_reg), "key count differs from used-letter mask")
    `KCD_ASSERT(a_new_letter_counts, add_new && !cmd.clear |=> count_reg == CNT_W'($past(count_reg) + CNT_W'(1)), "new key letter did not advance count")
    `KCD_ASSERT_AFTER_RESET(a_reset_empty, used_reg == '0 && count_reg == '0, "key not empty after reset")

endmodule

// File: hdl/keyword_cipher_decoder_unit.sv
// Keyword substitution cipher decoder: one character per beat.
// Top level; depends on kcd_pkg and kcd_key_store.
//
// Usage:
//   The slave channel (s_) carries commands: clear key, add a keyword
//   character, or decode a message character. Only decode beats produce a
//   beat on the master channel (m_), carrying the decoded byte.
//   A beat is taken into an input register, then key update or decode is done
//   in one pass of logic and the decoded byte lands in an output register.
//   A decode in the input register is written to the output register, and
//   so shows on m_tdata, once the input stage advances. Throughput: one
//   beat per cycle, limited only by the single output register.
//   When the receiver stalls, the output register holds its byte; a further
//   decode waits in the input register, and s_tready drops once both are full.
//   Clear and add beats keep flowing while a result is waiting.
//   Reset (aresetn low, synchronous) empties both registers and the key;
//   with an empty key every letter decodes to its own uppercase form.
`include "keyword_cipher_decoder_unit_macros.svh"

module keyword_cipher_decoder_unit
    import kcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] operation, [9:2] char_in, [15:10] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [7:0] char_out
);

    logic              in_valid_reg, in_valid_next;
    logic [OP_W-1:0]   in_op_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;

    logic              is_decode;
    logic              advance;
    logic              s_accept;
    letter_info_t      info;
    key_cmd_t          cmd;
    letter_mask_t      used;
    letter_mask_t      below_mask;
    logic [CNT_W-1:0]  key_count;
    logic [CNT_W-1:0]  stored_pos;
    logic [CNT_W-1:0]  pos;

    // Pipeline control: the input stage moves on unless it holds a decode
    // and the output register is full and stalled.
    assign is_decode = (in_op_reg == OP_DECODE);
    assign advance   = in_valid_reg && (!is_decode || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;

    assign in_valid_next  = s_accept || (in_valid_reg && !advance);
    assign out_valid_next = (advance && is_decode) || (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= s_tdata[1:0];
            in_char_reg <= s_tdata[9:2];
        end
    end

    // Key updates are issued once per beat, when it leaves the input stage.
    assign info      = letter_info(in_char_reg);
    assign cmd.clear = advance && (in_op_reg == OP_CLEAR);
    assign cmd.add   = advance && (in_op_reg == OP_ADD) && info.is_letter;
    assign cmd.idx   = info.idx;

    kcd_key_store u_key_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .rd_idx    (info.idx),
        .used      (used),
        .key_count (key_count),
        .rd_pos    (stored_pos)
    );

    // Letters outside the key follow the key letters in alphabetical order.
    assign below_mask = (letter_mask_t'(1) << info.idx) - letter_mask_t'(1);
    assign pos = used[info.idx] ? stored_pos
                                : key_count + count_letters(~used & below_mask);

    always_comb begin
        if (info.is_letter) begin
            out_char_next = CHAR_UPPER_A + CHAR_W'(pos);
        end else if (in_char_reg == CHAR_BACKTICK) begin
            out_char_next = CHAR_SPACE;
        end else begin
            out_char_next = in_char_reg;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (advance && is_decode) begin
            out_char_reg <= out_char_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;

    `KCD_ASSERT(a_ready_when_drained, !out_valid_reg |-> s_tready, "input stalled with empty output register")
    `KCD_ASSERT(a_result_from_decode, $rose(out_valid_reg) |-> $past(advance && is_decode), "result appeared without a decode")
    `KCD_ASSERT_AFTER_RESET(a_reset_idle, !in_valid_reg && !out_valid_reg, "pipeline not empty after reset")

endmodule
